[rtl/mbce_pkg.sv]
// ----------------------------------------------------------------------------
// mbce_pkg
// Shared types and constants for the monochrome color expansion blit.
// ----------------------------------------------------------------------------
package mbce_pkg;

   // largest bitmap or picture dimension honored
   localparam int MAX_DIMENSION_DEFAULT = 4096;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;
   localparam int DIM_REG_W   = 13;
   localparam int CENTER_W    = 14;
   localparam int COLOR_W     = 8;
   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 24;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_BITMAP_WIDTH   = 3'd0;
   localparam csr_index_type CSR_BITMAP_HEIGHT  = 3'd1;
   localparam csr_index_type CSR_PICTURE_WIDTH  = 3'd2;
   localparam csr_index_type CSR_PICTURE_HEIGHT = 3'd3;
   localparam csr_index_type CSR_CENTER_X       = 3'd4;
   localparam csr_index_type CSR_CENTER_Y       = 3'd5;
   localparam csr_index_type CSR_DRAW_COLOR     = 3'd6;

   localparam logic [DIM_REG_W-1:0] RESET_BITMAP_WIDTH   = 13'd8;
   localparam logic [DIM_REG_W-1:0] RESET_BITMAP_HEIGHT  = 13'd8;
   localparam logic [DIM_REG_W-1:0] RESET_PICTURE_WIDTH  = 13'd480;
   localparam logic [DIM_REG_W-1:0] RESET_PICTURE_HEIGHT = 13'd270;
   localparam logic [COLOR_W-1:0]   RESET_DRAW_COLOR     = 8'd1;

   // one byte's worth of writes handed to the expand unit
   typedef struct packed {
      logic [BYTE_W-1:0] mask;      // visible set pixels, bit 0 leftmost
      logic [ADDR_W-1:0] row_base;  // y * picture_width, low bits
      logic [ADDR_W-1:0] x0;        // column of bit 0, two's complement
   } expand_load_type;

endpackage

[rtl/mono_bitmap_color_expand_blit.sv]
// ----------------------------------------------------------------------------
// mono_bitmap_color_expand_blit
// Expands packed 1-bit bitmap bytes into color writes on a linear picture.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one packed bitmap byte per beat, least significant bit is
//   the leftmost pixel, rows padded to whole bytes, rows top to bottom.
//   rsp_* carries one pixel write per beat: address y * picture_width + x,
//   the draw color, and last_in_run on the final write of a byte.
//   csr_* writes the seven setup registers; write only while idle.
// Timing:
//   A byte enters the placement register, the row base product is formed
//   on the way into the expand unit's byte register, and the first write
//   of the byte then goes into the result register.
//   The expand unit issues one write per cycle while the result is not
//   stalled, one for each visible set pixel of a byte (0 to 8). Bytes with
//   no write give no beat.
// Reset clears the row and byte counters and loads the register defaults.
// A stalled result holds; the pipeline fills behind it and req_stall rises
// once the placement register cannot advance.
// ----------------------------------------------------------------------------
module mono_bitmap_color_expand_blit #(
   parameter int MAX_DIMENSION = mbce_pkg::MAX_DIMENSION_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mbce_pkg::BYTE_W-1:0]          req_bitmap_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbce_pkg::ADDR_W-1:0]          rsp_pixel_address,
   output logic [mbce_pkg::COLOR_W-1:0]         rsp_pixel_color,
   output logic                                 rsp_last_in_run,
   input  logic                                 csr_write,
   input  mbce_pkg::csr_index_type              csr_index,
   input  logic [mbce_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
   localparam int ROW_W  = $clog2(MAX_DIMENSION);
   localparam int BCNT_W = $clog2((MAX_DIMENSION + 7) / 8);
   localparam int SW     = ((DIM_W > mbce_pkg::CENTER_W) ? DIM_W : mbce_pkg::CENTER_W) + 2;
   localparam int PROD_W = 2 * DIM_W;

   // setup registers
   logic [mbce_pkg::DIM_REG_W-1:0]      bw_ff, bh_ff, pw_ff, ph_ff;
   logic signed [mbce_pkg::CENTER_W-1:0] cx_ff, cy_ff;
   logic [mbce_pkg::COLOR_W-1:0]        color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff    <= mbce_pkg::RESET_BITMAP_WIDTH;
         bh_ff    <= mbce_pkg::RESET_BITMAP_HEIGHT;
         pw_ff    <= mbce_pkg::RESET_PICTURE_WIDTH;
         ph_ff    <= mbce_pkg::RESET_PICTURE_HEIGHT;
         cx_ff    <= '0;
         cy_ff    <= '0;
         color_ff <= mbce_pkg::RESET_DRAW_COLOR;
      end else if (csr_write) begin
         case (csr_index)
            mbce_pkg::CSR_BITMAP_WIDTH:   bw_ff    <= csr_data[mbce_pkg::DIM_REG_W-1:0];
            mbce_pkg::CSR_BITMAP_HEIGHT:  bh_ff    <= csr_data[mbce_pkg::DIM_REG_W-1:0];
            mbce_pkg::CSR_PICTURE_WIDTH:  pw_ff    <= csr_data[mbce_pkg::DIM_REG_W-1:0];
            mbce_pkg::CSR_PICTURE_HEIGHT: ph_ff    <= csr_data[mbce_pkg::DIM_REG_W-1:0];
            mbce_pkg::CSR_CENTER_X:       cx_ff    <= $signed(csr_data);
            mbce_pkg::CSR_CENTER_Y:       cy_ff    <= $signed(csr_data);
            mbce_pkg::CSR_DRAW_COLOR:     color_ff <= csr_data[mbce_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped dimensions
   logic [DIM_W-1:0] bw_c, bh_c, pw_c, ph_c;

   always_comb begin
      bw_c = (int'(bw_ff) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(bw_ff);
      bh_c = (int'(bh_ff) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(bh_ff);
      pw_c = (int'(pw_ff) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(pw_ff);
      ph_c = (int'(ph_ff) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : DIM_W'(ph_ff);
      if (bw_ff == '0) begin
         bw_c = DIM_W'(1);
      end
      if (bh_ff == '0) begin
         bh_c = DIM_W'(1);
      end
   end

   // counters and placement stage
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic [mbce_pkg::BYTE_W-1:0]  s1_mask_ff, s1_mask_in;
   logic [DIM_W-1:0]             s1_y_ff, s1_y_in;
   logic [mbce_pkg::ADDR_W-1:0]  s1_x0_ff, s1_x0_in;

   logic signed [SW-1:0] bw_s, bh_s, pw_s, ph_s, bpr_s;
   logic signed [SW-1:0] row_s, bcnt_s, row_eff, bcnt_eff;
   logic signed [SW-1:0] y_s, x0_s, col0_s, col_s, x_s;
   logic signed [SW-1:0] bcnt_nxt, row_nxt;
   logic                 row_vis;
   logic [mbce_pkg::BYTE_W-1:0] mask_c;

   logic                       accept;
   logic                       load_ready;
   mbce_pkg::expand_load_type  load;
   logic [PROD_W-1:0]          prod;

   assign req_stall = s1_valid_ff && !load_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      bw_s   = SW'($signed({1'b0, bw_c}));
      bh_s   = SW'($signed({1'b0, bh_c}));
      pw_s   = SW'($signed({1'b0, pw_c}));
      ph_s   = SW'($signed({1'b0, ph_c}));
      bpr_s  = (bw_s + SW'(7)) >>> 3;
      row_s  = SW'($signed({1'b0, row_ff}));
      bcnt_s = SW'($signed({1'b0, bcnt_ff}));

      // restart a counter left out of bounds by a setup change
      row_eff  = (row_s >= bh_s) ? '0 : row_s;
      bcnt_eff = (bcnt_s >= bpr_s) ? '0 : bcnt_s;

      col0_s  = bcnt_eff <<< 3;
      y_s     = SW'(cy_ff) - (bh_s >>> 1) + row_eff;
      x0_s    = SW'(cx_ff) - (bw_s >>> 1) + col0_s;
      row_vis = (y_s >= 0) && (y_s < ph_s);

      mask_c = '0;
      col_s  = '0;
      x_s    = '0;
      for (int b = 0; b < mbce_pkg::BYTE_W; b++) begin
         col_s = col0_s + SW'(b);
         x_s   = x0_s + SW'(b);
         mask_c[b] = req_bitmap_byte[b] && row_vis && (col_s < bw_s)
                     && (x_s >= 0) && (x_s < pw_s);
      end

      // advance byte, then row, wrapping after the last row
      bcnt_nxt = bcnt_eff + SW'(1);
      row_nxt  = row_eff;
      if (bcnt_nxt >= bpr_s) begin
         bcnt_nxt = '0;
         row_nxt  = row_eff + SW'(1);
         if (row_nxt >= bh_s) begin
            row_nxt = '0;
         end
      end
   end

   always_comb begin
      row_in      = row_ff;
      bcnt_in     = bcnt_ff;
      s1_valid_in = s1_valid_ff;
      s1_mask_in  = s1_mask_ff;
      s1_y_in     = s1_y_ff;
      s1_x0_in    = s1_x0_ff;
      if (accept) begin
         row_in      = ROW_W'(row_nxt);
         bcnt_in     = BCNT_W'(bcnt_nxt);
         s1_valid_in = 1'b1;
         s1_mask_in  = mask_c;
         s1_y_in     = DIM_W'(y_s);
         s1_x0_in    = mbce_pkg::ADDR_W'(x0_s);
      end else if (load_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         bcnt_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         bcnt_ff     <= bcnt_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_mask_ff <= s1_mask_in;
      s1_y_ff    <= s1_y_in;
      s1_x0_ff   <= s1_x0_in;
   end

   // row base product, registered inside the expand unit
   assign prod          = PROD_W'(s1_y_ff) * PROD_W'(pw_c);
   assign load.mask     = s1_mask_ff;
   assign load.row_base = mbce_pkg::ADDR_W'(prod);
   assign load.x0       = s1_x0_ff;

   mbce_expand u_expand (
      .clock             (clock),
      .reset             (reset),
      .load_valid        (s1_valid_ff),
      .load_ready        (load_ready),
      .load              (load),
      .color             (color_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_in_run   (rsp_last_in_run)
   );

endmodule

[rtl/mbce_expand.sv]
// ----------------------------------------------------------------------------
// mbce_expand
// Issues one pixel write per cycle while the result is not stalled, for each
// visible set bit of a byte, left to right, through a registered result stage.
// ----------------------------------------------------------------------------
module mbce_expand (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_valid,
   output logic                                 load_ready,
   input  mbce_pkg::expand_load_type            load,
   input  logic [mbce_pkg::COLOR_W-1:0]         color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbce_pkg::ADDR_W-1:0]          rsp_pixel_address,
   output logic [mbce_pkg::COLOR_W-1:0]         rsp_pixel_color,
   output logic                                 rsp_last_in_run
);

   logic                             busy_ff, busy_in;
   logic [mbce_pkg::BYTE_W-1:0]      mask_ff, mask_in;
   logic [mbce_pkg::ADDR_W-1:0]      base_ff, base_in;
   logic [mbce_pkg::ADDR_W-1:0]      x0_ff, x0_in;

   logic                             out_valid_ff, out_valid_in;
   logic [mbce_pkg::ADDR_W-1:0]      out_addr_ff, out_addr_in;
   logic [mbce_pkg::COLOR_W-1:0]     out_color_ff, out_color_in;
   logic                             out_last_ff, out_last_in;

   logic                             out_free;
   logic                             emit;
   logic [mbce_pkg::BYTE_W-1:0]      pick;
   logic [mbce_pkg::BYTE_W-1:0]      rest;
   logic [2:0]                       pick_idx;
   logic                             final_bit;

   always_comb begin
      pick_idx = 3'd0;
      for (int b = mbce_pkg::BYTE_W - 1; b >= 0; b--) begin
         if (mask_ff[b]) begin
            pick_idx = 3'(b);
         end
      end
   end

   assign pick      = mask_ff & (~mask_ff + 8'd1);
   assign rest      = mask_ff & ~pick;
   assign final_bit = (rest == '0);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign load_ready = !busy_ff || (emit && final_bit);

   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      base_in = base_ff;
      x0_in   = x0_ff;
      if (load_valid && load_ready) begin
         // drop bytes with nothing to draw
         busy_in = (load.mask != '0);
         mask_in = load.mask;
         base_in = load.row_base;
         x0_in   = load.x0;
      end else if (emit) begin
         mask_in = rest;
         busy_in = !final_bit;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_addr_in  = base_ff + x0_ff + mbce_pkg::ADDR_W'(pick_idx);
         out_color_in = color;
         out_last_in  = final_bit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      mask_ff      <= mask_in;
      base_ff      <= base_in;
      x0_ff        <= x0_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last_in_run   = out_last_ff;

endmodule
